>>> rtl/message_reassembly_tracker_macros.svh
// ----------------------------------------------------------------------------
// Message reassembly tracker assertion macros
// Concurrent check wrappers on clk with synchronous rst as disable.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_REASSEMBLY_TRACKER_MACROS_SVH
`define MESSAGE_REASSEMBLY_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MRT_ASSERT_NOW(lbl, ante, cons, msg)
`define MRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// Field widths and codes shared by the reassembly tracker modules.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int OFF_W = 20;
  localparam int LEN_W = 21;
  localparam int NB_W  = 11;
  localparam int ST_W  = 2;

  localparam logic [NB_W-1:0] NB_MAX = 11'd2047;

  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [1:0] {
    PH_WAITING  = 2'd0,
    PH_INCOMING = 2'd1,
    PH_READY    = 2'd2
  } phase_t;

  typedef enum logic [ST_W-1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_REDUNDANT   = 2'd1,
    ST_WRONG_STATE = 2'd2,
    ST_FULL        = 2'd3
  } status_t;

endpackage

>>> rtl/message_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// message_reassembly_tracker
// Byte range tracker for one incoming message with a sorted offset table.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | opcode, packet_offset, msg_len
//  out     | out_valid / out_stall| status, new_bytes, bytes_left, ready_res
//
// Arm and dropped beats go straight to the output. A data beat searches the
// table backward from the last entry for its predecessor, clamps, checks,
// moves later entries up, adds its gain and emits; redundant or full: no moves
// and no gain step. The registered table read and the one subtract/compare unit set these steps.
// in_stall is high until the result enters the output register, which holds
// under out_stall while the next beat is taken. rst is synchronous.
// ----------------------------------------------------------------------------
`include "message_reassembly_tracker_macros.svh"

module message_reassembly_tracker #(
  parameter int MAX_PAYLOAD = 1400,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [mrt_pkg::OFF_W-1:0]    packet_offset,
  input  logic [mrt_pkg::LEN_W-1:0]    msg_len,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mrt_pkg::ST_W-1:0]     status,
  output logic [mrt_pkg::NB_W-1:0]     new_bytes,
  output logic [mrt_pkg::LEN_W-1:0]    bytes_left,
  output logic                         ready_res
);
  import mrt_pkg::*;

  localparam int PW   = $clog2(MAX_PAYLOAD + 1);
  localparam int SUMW = (PW > OFF_W ? PW : OFF_W) + 1;
  localparam int VW   = (SUMW > LEN_W ? SUMW : LEN_W);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam logic [VW-1:0] LIM  = VW'(MAX_PAYLOAD);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_CMP, S_CLAMP_LO, S_CLAMP_HI, S_CHECK,
    S_SHIFT, S_SHW, S_GAIN, S_FINAL, S_EMIT
  } state_t;

  state_t           state;
  phase_t           phase;
  logic [OFF_W-1:0] off;
  logic [VW-1:0]    floor_b;
  logic [VW-1:0]    ceil_b;
  logic [VW-1:0]    gain;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    count;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] total;
  status_t          res_status;
  logic             res_ready;

  logic             in_acc;
  logic             slot_free;
  logic [VW-1:0]    off_ext;
  logic [VW-1:0]    off_lim;
  logic [VW-1:0]    alu_a;
  logic [VW-1:0]    alu_b;
  logic [VW-1:0]    alu_diff;
  logic             alu_lt;
  logic [CW-1:0]    pos_m1;
  logic [CW-1:0]    idx_m1;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [OFF_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [OFF_W-1:0] mem_rdata;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign off_ext   = VW'(off);
  assign off_lim   = off_ext + LIM;
  assign pos_m1    = pos - 1'b1;
  assign idx_m1    = idx - 1'b1;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_CMP: begin
        alu_a = VW'(mem_rdata);
        alu_b = off_ext;
      end
      S_CLAMP_LO: begin
        alu_a = floor_b;
        alu_b = off_ext;
      end
      S_CLAMP_HI: begin
        alu_a = off_lim;
        alu_b = ceil_b;
      end
      S_CHECK: begin
        alu_a = ceil_b;
        alu_b = floor_b;
      end
      S_GAIN: begin
        alu_a = VW'(rem);
        alu_b = gain;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_m1[AW-1:0];
    case (state)
      S_SEARCH: mem_raddr = pos_m1[AW-1:0];
      S_SHIFT: begin
        if (idx == pos) begin
          mem_we    = 1'b1;
          mem_waddr = pos[AW-1:0];
          mem_wdata = off;
        end
      end
      S_SHW: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  mrt_alu #(.W(VW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .lt   (alu_lt)
  );

  mrt_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_WAITING;
      count     <= '0;
      rem       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            off     <= packet_offset;
            floor_b <= '0;
            gain    <= '0;
            pos     <= count;
            if (opcode == OP_ARM) begin
              phase      <= PH_WAITING;
              count      <= '0;
              total      <= '0;
              rem        <= '0;
              res_status <= ST_ACCEPTED;
              res_ready  <= 1'b0;
              state      <= S_EMIT;
            end else if (phase == PH_WAITING) begin
              total  <= msg_len;
              rem    <= msg_len;
              phase  <= PH_INCOMING;
              ceil_b <= VW'(msg_len);
              state  <= S_SEARCH;
            end else if (phase == PH_INCOMING) begin
              ceil_b <= VW'(total);
              state  <= S_SEARCH;
            end else begin
              res_status <= ST_WRONG_STATE;
              res_ready  <= 1'b0;
              state      <= S_EMIT;
            end
          end
        end
        S_SEARCH: begin
          state <= (pos == '0) ? S_CLAMP_LO : S_CMP;
        end
        S_CMP: begin
          if (alu_lt) begin
            floor_b <= VW'(mem_rdata) + LIM;
            state   <= S_CLAMP_LO;
          end else begin
            ceil_b <= VW'(mem_rdata);
            pos    <= pos_m1;
            state  <= S_SEARCH;
          end
        end
        S_CLAMP_LO: begin
          if (alu_lt) begin
            floor_b <= off_ext;
          end
          state <= S_CLAMP_HI;
        end
        S_CLAMP_HI: begin
          if (alu_lt) begin
            ceil_b <= off_lim;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          idx <= count;
          if (alu_lt || alu_diff == '0) begin
            res_status <= ST_REDUNDANT;
            state      <= S_FINAL;
          end else if (count == FULL) begin
            res_status <= ST_FULL;
            state      <= S_FINAL;
          end else begin
            gain  <= alu_diff;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (idx == pos) begin
            count <= count + 1'b1;
            state <= S_GAIN;
          end else begin
            state <= S_SHW;
          end
        end
        S_SHW: begin
          idx   <= idx_m1;
          state <= S_SHIFT;
        end
        S_GAIN: begin
          if (alu_lt) begin
            gain <= VW'(rem);
            rem  <= '0;
          end else begin
            rem <= alu_diff[LEN_W-1:0];
          end
          res_status <= ST_ACCEPTED;
          state      <= S_FINAL;
        end
        S_FINAL: begin
          res_ready <= (rem == '0);
          if (rem == '0) begin
            phase <= PH_READY;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            new_bytes  <= (gain > VW'(NB_MAX)) ? NB_MAX : gain[NB_W-1:0];
            bytes_left <= rem;
            ready_res  <= res_ready;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRT_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL, "entry count above table depth")
  `MRT_ASSERT_NOW(a_pos_bound, state == S_SEARCH, pos <= count, "search position past count")
  `MRT_ASSERT_NEXT(a_insert_inc, state == S_SHIFT && idx == pos,
                   count == $past(count) + 1'b1, "insert did not grow table")
  `MRT_ASSERT_NEXT(a_ready_drop, in_acc && opcode == OP_DATA && phase == PH_READY,
                   state == S_EMIT && res_status == ST_WRONG_STATE,
                   "packet after completion not dropped")
  `MRT_ASSERT_NOW(a_ready_empty, out_valid && ready_res, bytes_left == '0,
                  "ready reported with bytes left")
endmodule

>>> rtl/mrt_alu.sv
// ----------------------------------------------------------------------------
// mrt_alu
// Shared subtract/compare unit: a - b and a < b from one borrow chain.
// ----------------------------------------------------------------------------
module mrt_alu #(
  parameter int W = 21
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         lt
);
  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign lt   = full[W];
endmodule

>>> rtl/mrt_table.sv
// ----------------------------------------------------------------------------
// mrt_table
// Offset table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrt_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [mrt_pkg::OFF_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [mrt_pkg::OFF_W-1:0] rdata
);
  import mrt_pkg::*;

  logic [OFF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for message_reassembly_tracker. A local tracker keeps
// its own offset table and byte counts and predicts one result per beat.
// Directed beats cover the edge cases. Random messages follow, mostly
// well-formed with shuffled, overlapping or missing packets.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import mrt_pkg::*;

  localparam int MAX_PAYLOAD = 1400;
  localparam int TABLE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [LEN_W-1:0] LEN_TOP = 21'd1048576;
  localparam logic [OFF_W-1:0] OFF_TOP = 20'hFFFFF;

  typedef struct packed {
    status_t            st;
    logic [NB_W-1:0]    nb;
    logic [LEN_W-1:0]   left;
    logic               rdy;
  } tally_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [OFF_W-1:0]    packet_offset;
  logic [LEN_W-1:0]    msg_len;
  logic                out_valid;
  logic                out_stall;
  logic [ST_W-1:0]     status;
  logic [NB_W-1:0]     new_bytes;
  logic [LEN_W-1:0]    bytes_left;
  logic                ready_res;

  // tracker state
  phase_t              trk_phase;
  int unsigned         trk_left;
  int unsigned         trk_total;
  int unsigned         trk_count;
  logic [OFF_W-1:0]    seen_offsets [TABLE_DEPTH];

  tally_t              expected_tally [$];
  int unsigned         beats_sent;
  int unsigned         mismatches;
  int unsigned         cycle_count;
  int unsigned         send_idle_pct;
  int unsigned         stall_pct;

  message_reassembly_tracker #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .packet_offset(packet_offset),
    .msg_len(msg_len),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .new_bytes(new_bytes),
    .bytes_left(bytes_left),
    .ready_res(ready_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tally_t track_beat(input logic op, input logic [OFF_W-1:0] off,
                                        input logic [LEN_W-1:0] mlen);
    tally_t      r;
    int unsigned flo;
    int unsigned cei;
    int unsigned pos;
    int unsigned gain;
    int unsigned i;
    logic        found;
    r.st   = ST_ACCEPTED;
    r.nb   = '0;
    r.left = '0;
    r.rdy  = 1'b0;
    if (op == OP_ARM) begin
      trk_phase = PH_WAITING;
      trk_count = 0;
      trk_total = 0;
      trk_left  = 0;
      return r;
    end
    if (trk_phase == PH_WAITING) begin
      trk_total = mlen;
      trk_left  = mlen;
      trk_phase = PH_INCOMING;
    end else if (trk_phase != PH_INCOMING) begin
      r.st   = ST_WRONG_STATE;
      r.left = trk_left[LEN_W-1:0];
      return r;
    end
    flo   = 0;
    cei   = trk_total;
    pos   = trk_count;
    found = 1'b0;
    while (pos > 0 && !found) begin
      if (seen_offsets[pos-1] < off) begin
        flo   = seen_offsets[pos-1] + MAX_PAYLOAD;
        found = 1'b1;
      end else begin
        cei = seen_offsets[pos-1];
        pos--;
      end
    end
    if (flo < off) flo = off;
    if (cei > off + MAX_PAYLOAD) cei = off + MAX_PAYLOAD;
    gain = 0;
    if (flo >= cei) begin
      r.st = ST_REDUNDANT;
    end else if (trk_count >= TABLE_DEPTH) begin
      r.st = ST_FULL;
    end else begin
      for (i = trk_count; i > pos; i--) seen_offsets[i] = seen_offsets[i-1];
      seen_offsets[pos] = off;
      trk_count++;
      gain = cei - flo;
      if (gain > trk_left) gain = trk_left;
      trk_left -= gain;
      r.st = ST_ACCEPTED;
    end
    if (trk_left == 0) begin
      trk_phase = PH_READY;
      r.rdy = 1'b1;
    end
    r.nb   = (gain > 2047) ? NB_MAX : gain[NB_W-1:0];
    r.left = trk_left[LEN_W-1:0];
    return r;
  endfunction

  task automatic send_beat(input logic op, input logic [OFF_W-1:0] off,
                           input logic [LEN_W-1:0] mlen);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    packet_offset <= off;
    msg_len       <= mlen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_tally.push_back(track_beat(op, off, mlen));
    beats_sent++;
  endtask

  task automatic set_idling(input int unsigned sender, input int unsigned receiver);
    send_idle_pct = sender;
    stall_pct     = receiver;
  endtask

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    tally_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tally.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status %0d new_bytes %0d bytes_left %0d ready %0d",
                   status, new_bytes, bytes_left, ready_res);
      end else begin
        want = expected_tally.pop_front();
        if (status !== want.st || new_bytes !== want.nb || bytes_left !== want.left ||
            ready_res !== want.rdy) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d nb %0d left %0d rdy %0d, ",
                      "got st %0d nb %0d left %0d rdy %0d"},
                     want.st, want.nb, want.left, want.rdy,
                     status, new_bytes, bytes_left, ready_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[message_reassembly_tracker] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(OP_DATA, 20'd0, 21'd3000);      // first beat after reset sets total
    send_beat(OP_DATA, 20'd0, 21'd0);         // duplicate
    send_beat(OP_DATA, 20'd700, 21'd5);       // partial overlap
    send_beat(OP_DATA, 20'd2800, 21'd0);      // clipped by total
    send_beat(OP_DATA, 20'd1400, LEN_TOP);    // out of order, completes
    send_beat(OP_DATA, 20'd0, 21'd0);         // ready: dropped
    send_beat(OP_ARM, OFF_TOP, LEN_TOP);
    send_beat(OP_DATA, 20'd0, 21'd0);         // zero length message
    send_beat(OP_DATA, 20'd100, 21'd100);
    send_beat(OP_ARM, 20'd0, 21'd0);
    send_beat(OP_DATA, OFF_TOP, LEN_TOP);
    send_beat(OP_DATA, OFF_TOP, 21'h1FFFFF);
    send_beat(OP_DATA, 20'd0, 21'd0);
    send_beat(OP_ARM, 20'd0, 21'd0);
    send_beat(OP_DATA, 20'd0, 21'd1);
    send_beat(OP_ARM, 20'd0, 21'd0);
    send_beat(OP_DATA, 20'd5000, 21'd2000);   // beyond the end
    send_beat(OP_DATA, 20'd600, 21'd0);
    send_beat(OP_DATA, 20'd0, 21'd0);
    send_beat(OP_ARM, 20'd0, 21'd0);
  endtask

  task automatic run_message();
    int unsigned len;
    int unsigned npk;
    int unsigned k;
    int unsigned a;
    int unsigned b;
    int unsigned tmp;
    int unsigned pick;
    int unsigned offs [$];
    pick = $urandom_range(99);
    if (pick < 8) len = 0;
    else if (pick < 20) len = $urandom_range(1048576, 12001);
    else len = $urandom_range(12000, 1);
    send_beat(OP_ARM, OFF_W'($urandom), LEN_W'($urandom_range(1048576, 0)));
    if (len > 12000) begin
      repeat ($urandom_range(6, 2)) offs.push_back($urandom_range(1048575, 0));
    end else begin
      npk = (len + MAX_PAYLOAD - 1) / MAX_PAYLOAD;
      for (k = 0; k < npk; k++)
        if ($urandom_range(9) != 0) offs.push_back(k * MAX_PAYLOAD);
      repeat ($urandom_range(3, 0)) offs.push_back($urandom_range(len + MAX_PAYLOAD, 0));
    end
    if (offs.size() == 0) offs.push_back(0);
    if ($urandom_range(1) == 1) begin
      repeat (offs.size()) begin
        a = $urandom_range(offs.size() - 1, 0);
        b = $urandom_range(offs.size() - 1, 0);
        tmp = offs[a];
        offs[a] = offs[b];
        offs[b] = tmp;
      end
    end
    for (k = 0; k < offs.size(); k++)
      send_beat(OP_DATA, OFF_W'(offs[k]),
                (k == 0) ? LEN_W'(len) : LEN_W'($urandom_range(1048576, 0)));
    if ($urandom_range(2) == 0)
      send_beat(OP_DATA, OFF_W'($urandom), LEN_W'($urandom_range(1048576, 0)));
  endtask

  task automatic test_random_messages(input int unsigned quota);
    int unsigned goal;
    goal = beats_sent + quota;
    while (beats_sent < goal) begin
      if ($urandom_range(99) < 15)
        send_beat(OP_ARM ^ logic'($urandom_range(1)), OFF_W'($urandom),
                  LEN_W'($urandom_range(1048576, 0)));
      else
        run_message();
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tally.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[message_reassembly_tracker] OK");
    end else begin
      $display("[message_reassembly_tracker] ERROR");
    end
    $finish;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_ARM;
    packet_offset = '0;
    msg_len       = '0;
    out_stall     = 1'b0;
    beats_sent    = 0;
    mismatches    = 0;
    cycle_count   = 0;
    trk_phase     = PH_WAITING;
    trk_left      = 0;
    trk_total     = 0;
    trk_count     = 0;
    set_idling(0, 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idling(20, 62);
    test_directed();
    test_random_messages(210);
    set_idling(62, 20);
    test_random_messages(210);
    set_idling(0, 0);
    test_random_messages(210);
    finish_run();
  end

endmodule
